// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    localparam int OPERAND_BITS = 32;
    localparam int CNT_W        = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] exponent;
        logic [31:0] modulus;
    } t_in;

    typedef struct packed {
        logic [31:0] power_result;
        logic        bad_modulus;
    } t_out;

    typedef enum logic [1:0] {
        OP_RED,
        OP_MUL,
        OP_SQR
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_ST,
        S_RED_WT,
        S_BIT,
        S_MUL_WT,
        S_SQR_ST,
        S_SQR_WT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
        logic shift_exp;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic exp_lsb;
        logic mul_done;
        logic bad;
        logic out_free;
    } t_status;

    // v < 2m assumed: one conditional subtract
    function automatic logic [OPERAND_BITS-1:0] mod_fix(
        input logic [OPERAND_BITS:0]   v,
        input logic [OPERAND_BITS-1:0] m
    );
        logic [OPERAND_BITS:0] d;
        d = v - {1'b0, m};
        if (v >= {1'b0, m}) begin
            return d[OPERAND_BITS-1:0];
        end
        return v[OPERAND_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mexp_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// interleaved shift-and-add modular multiply, a doubling phase and an adding phase per multiplier bit
module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [OPERAND_BITS-1:0] i_a,
    input  wire logic [OPERAND_BITS-1:0] i_b,
    input  wire logic [OPERAND_BITS-1:0] i_m,
    output logic                         o_done,
    output logic [OPERAND_BITS-1:0]      o_prod
);

    logic                    r_busy, n_busy;
    logic                    r_ph, n_ph;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [OPERAND_BITS-1:0] r_pr, n_pr;
    logic [OPERAND_BITS-1:0] r_mx, n_mx;
    logic [OPERAND_BITS-1:0] r_my, n_my;
    logic [OPERAND_BITS-1:0] w_dbl, w_add, w_addend;

    // phase 0 doubles, phase 1 adds the multiplicand when the top bit is set
    assign w_addend = r_my[OPERAND_BITS-1] ? r_mx : {OPERAND_BITS{1'b0}};
    assign w_dbl    = mod_fix({r_pr, 1'b0}, i_m);
    assign w_add    = mod_fix({1'b0, r_pr} + {1'b0, w_addend}, i_m);
    assign o_done   = r_busy && r_ph && (r_cnt == CNT_W'(OPERAND_BITS - 1));
    assign o_prod   = w_add;

    always_comb begin
        n_busy = r_busy;
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_pr   = r_pr;
        n_mx   = r_mx;
        n_my   = r_my;
        if (i_start) begin
            n_busy = 1'b1;
            n_ph   = 1'b0;
            n_cnt  = '0;
            n_pr   = '0;
            n_mx   = i_a;
            n_my   = i_b;
        end else if (r_busy) begin
            if (!r_ph) begin
                n_pr = w_dbl;
                n_ph = 1'b1;
            end else begin
                n_pr = w_add;
                n_ph = 1'b0;
                n_my = {r_my[OPERAND_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (o_done) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_ph   <= n_ph;
            r_cnt  <= n_cnt;
        end
        r_pr <= n_pr;
        r_mx <= n_mx;
        r_my <= n_my;
    end

endmodule

`default_nettype wire

// ===== rtl/mexp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp
    import mexp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in,
    input  wire t_cmd i_cmd,
    input  wire logic i_ready,
    output t_status   o_status,
    output logic      o_valid,
    output t_out      o_out
);

    logic [OPERAND_BITS-1:0] r_m, r_e, r_b, r_acc, r_run;
    logic                    r_bad;
    t_op                     r_op;
    t_out                    r_out;
    logic                    r_out_valid;
    logic [OPERAND_BITS-1:0] w_in_m, w_one, w_a, w_b, w_prod;
    logic                    w_done;

    assign w_in_m = i_in.modulus[OPERAND_BITS-1:0];
    // 1 mod m, zero when the modulus is one
    assign w_one  = (w_in_m == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);

    always_comb begin
        case (i_cmd.op)
            OP_RED: begin
                w_a = r_acc;
                w_b = r_b;
            end
            OP_MUL: begin
                w_a = r_acc;
                w_b = r_run;
            end
            OP_SQR: begin
                w_a = r_run;
                w_b = r_run;
            end
            default: begin
                w_a = r_run;
                w_b = r_run;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (r_m),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m   <= w_in_m;
            r_e   <= i_in.exponent[OPERAND_BITS-1:0];
            r_b   <= i_in.base[OPERAND_BITS-1:0];
            r_acc <= w_one;
            r_bad <= (w_in_m == '0);
        end
        if (i_cmd.start) begin
            r_op <= i_cmd.op;
        end
        if (w_done) begin
            if (r_op == OP_MUL) begin
                r_acc <= w_prod;
            end else begin
                r_run <= w_prod;
            end
        end
        if (i_cmd.shift_exp) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.publish) begin
            r_out.power_result <= r_bad ? 32'd0 : 32'(r_acc);
            r_out.bad_modulus  <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    assign o_status.exp_lsb  = r_e[0];
    assign o_status.mul_done = w_done;
    assign o_status.bad      = r_bad;
    assign o_status.out_free = !r_out_valid || i_ready;

endmodule

`default_nettype wire

// ===== rtl/mexp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_status i_status,
    output logic         o_ready,
    output t_cmd         o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        o_ready = 1'b0;
        o_cmd   = '{load: 1'b0, start: 1'b0, op: OP_RED, shift_exp: 1'b0, publish: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit      = '0;
                    n_state    = S_RED_ST;
                end
            end
            S_RED_ST: begin
                if (i_status.bad) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = OP_RED;
                    n_state     = S_RED_WT;
                end
            end
            S_RED_WT: begin
                if (i_status.mul_done) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (i_status.exp_lsb) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = OP_MUL;
                    n_state     = S_MUL_WT;
                end else begin
                    n_state = S_SQR_ST;
                end
            end
            S_MUL_WT: begin
                if (i_status.mul_done) begin
                    n_state = S_SQR_ST;
                end
            end
            S_SQR_ST: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = OP_SQR;
                n_state     = S_SQR_WT;
            end
            S_SQR_WT: begin
                if (i_status.mul_done) begin
                    o_cmd.shift_exp = 1'b1;
                    if (r_bit == CNT_W'(OPERAND_BITS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_bit   = r_bit + 1'b1;
                        n_state = S_BIT;
                    end
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// modular exponentiation, base^exponent mod modulus, by right-to-left binary
// square-and-multiply. one item is worked on at a time: after an input transfer
// the block drops o_ready until the result is moved into the output register,
// which can still hold the previous result while the next item computes. every
// modular multiply runs on one shared interleaved shift-and-add unit, which is
// started and then doubles and adds once per multiplier bit. the base is first
// reduced with one such multiply, then each exponent bit passes a decision state
// and a squaring, plus a multiply when the bit is set. the result is loaded once
// the output register is free, and o_ready returns in the cycle after the load.
// a zero modulus skips all arithmetic and loads 0 with bad_modulus set.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // input channel
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_in,
    // result channel
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_out
);

    // command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: bit loop over the exponent and multiply scheduling
    mexp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    // operand registers, multiply unit and output register
    mexp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (w_cmd),
        .i_ready  (i_ready),
        .o_status (w_status),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/mexp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_checker
    import mexp_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire t_in  i_in,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_out
);

    // a result that is not taken stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out))
        else $error("result changed while stalled");

    // a waiting input keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_in))
        else $error("input changed before transfer");

    // one item in work at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while an item is in work");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.bad_modulus |-> o_out.power_result == 32'd0)
        else $error("bad modulus with nonzero result");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);

`default_nettype wire
